>>> rtl/core/shaker_sort_engine_defines.svh
// Assertion macros used by the sorter RTL.
`ifndef SHAKER_SORT_ENGINE_DEFINES_SVH
`define SHAKER_SORT_ENGINE_DEFINES_SVH

// Property that must hold at every clock edge outside of reset.
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

  // Default number of cells in the chain.
  localparam int unsigned MaxElements = 16;

  localparam int unsigned DataWidth = 32;

  // Input item: one element of the set.
  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last;
  } in_item_t;

  // Result item: one element of the sorted run.
  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        last_out;
  } out_item_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_e;

  // State a cell shows to its neighbors.
  typedef struct packed {
    logic                        valid;
    logic                        less;
    logic signed [DataWidth-1:0] value;
  } cell_t;

  // Sequencer states.
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sse_state_e;

endpackage

>>> rtl/core/sse_cell.sv
`timescale 1ns / 1ps

// One cell of the sorting chain. The occupied cells always hold an ascending
// run starting at cell 0, so an incoming value lands in the first cell that is empty or
// whose value is larger, and every cell above that one takes its left neighbor's value.
module sse_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sse_pkg::cell_cmd_e                   cmd_i,
  input  logic signed [sse_pkg::DataWidth-1:0] insert_value_i,
  input  sse_pkg::cell_t                       left_i,
  input  sse_pkg::cell_t                       right_i,
  output sse_pkg::cell_t                       cell_o
);

  logic                                 valid_q, valid_d;
  logic signed [sse_pkg::DataWidth-1:0] value_q, value_d;
  logic                                 less;

  // The new value belongs at or before this cell when the cell is empty or larger.
  assign less = !valid_q || (insert_value_i < value_q);

  // Next cell contents.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    case (cmd_i)
      sse_pkg::CELL_INSERT: begin
        if (less) begin
          value_d = left_i.less ? left_i.value : insert_value_i;
          valid_d = valid_q | left_i.valid;
        end
      end
      sse_pkg::CELL_SHIFT: begin
        value_d = right_i.value;
        valid_d = right_i.valid;
      end
      default: begin
        valid_d = valid_q;
        value_d = value_q;
      end
    endcase
  end

  // Occupancy is control state; the value needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.less  = less;
  assign cell_o.value = value_q;

endmodule

>>> rtl/core/shaker_sort_engine.sv
// Loading: each input transfer is inserted into the cell chain unless the chain is full; the first
// result is offered in the cycle after the transfer that carries last.
// Throughput: one input per cycle while loading, one result per cycle while draining and
// out_ready_i is high.
// Reset: asynchronous, active low; it empties every cell and returns to loading.
`timescale 1ns / 1ps

`include "shaker_sort_engine_defines.svh"

module shaker_sort_engine #(
  parameter int unsigned MAX_ELEMENTS = sse_pkg::MaxElements
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sse_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sse_pkg::out_item_t out_data_o
);

  sse_pkg::sse_state_e state_q, state_d;
  sse_pkg::cell_cmd_e  cmd;
  sse_pkg::cell_t      chain [MAX_ELEMENTS];
  logic                in_fire;
  logic                out_fire;
  logic                full;
  logic                final_result;

  assign in_fire      = in_valid_i && in_ready_o;
  assign out_fire     = out_valid_o && out_ready_i;
  assign full         = chain[MAX_ELEMENTS-1].valid;
  assign final_result = !chain[1].valid;

  // Row of cells; cell 0 sees an occupied, smaller neighbor on its left.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    sse_pkg::cell_t left_cell;
    sse_pkg::cell_t right_cell;

    if (i == 0) begin : g_first
      assign left_cell = '{valid: 1'b1, less: 1'b0, value: '0};
    end else begin : g_inner_left
      assign left_cell = chain[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign right_cell = '{valid: 1'b0, less: 1'b1, value: '0};
    end else begin : g_inner_right
      assign right_cell = chain[i+1];
    end

    sse_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .insert_value_i (in_data_i.value),
      .left_i         (left_cell),
      .right_i        (right_cell),
      .cell_o         (chain[i])
    );
  end

  // Next state: a closing transfer starts the drain, the final result ends it.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sse_pkg::ST_LOAD: begin
        if (in_fire && in_data_i.last) begin
          state_d = sse_pkg::ST_DRAIN;
        end
      end
      sse_pkg::ST_DRAIN: begin
        if (out_fire && final_result) begin
          state_d = sse_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = sse_pkg::ST_LOAD;
      end
    endcase
  end

  // Handshakes and chain command. Values arriving at a full chain are dropped.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd         = sse_pkg::CELL_HOLD;
    case (state_q)
      sse_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !full) begin
          cmd = sse_pkg::CELL_INSERT;
        end
      end
      sse_pkg::ST_DRAIN: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd = sse_pkg::CELL_SHIFT;
        end
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
        cmd         = sse_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sse_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // The smallest element sits in cell 0.
  assign out_data_o.sorted_value = chain[0].value;
  assign out_data_o.last_out     = final_result;

  `SSE_ASSERT(a_one_side_open, clk_i, rst_ni, !(in_ready_o && out_valid_o), "both sides open")
  `SSE_ASSERT_NEXT(a_close_fills, clk_i, rst_ni, in_fire && in_data_i.last, chain[0].valid, "empty chain after closing transfer")
  `SSE_ASSERT_NEXT(a_drain_ends, clk_i, rst_ni, out_fire && final_result, in_ready_o && !chain[0].valid, "chain not empty after final result")

  for (genvar j = 0; j < MAX_ELEMENTS - 1; j++) begin : g_chk
    `SSE_ASSERT(a_prefix, clk_i, rst_ni, !chain[j+1].valid || chain[j].valid, "gap in occupied cells")
    `SSE_ASSERT(a_order, clk_i, rst_ni, !chain[j+1].valid || (chain[j].value <= chain[j+1].value), "chain out of order")
  end

endmodule
